[rtl/aad_pkg.sv]
// ----------------------------------------------------------------------------
// Adaptive axis deadband package
// Field widths, register indexes and the shared absolute-difference function.
// ----------------------------------------------------------------------------
package aad_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int TIME_W     = 32;
  localparam int SIZE_W     = 15;
  localparam int SETTLE_W   = 16;
  localparam int MOV_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADBAND_SIZE   = 1'b0,
    CFG_SETTLE_DURATION = 1'b1
  } cfg_reg_t;

  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd500;

  // Magnitude of a - b for two signed samples; one bit wider than a sample.
  function automatic logic [SAMPLE_W:0] abs_diff(input logic signed [SAMPLE_W-1:0] a,
                                                 input logic signed [SAMPLE_W-1:0] b);
    logic [SAMPLE_W:0] d;
    d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
    return d[SAMPLE_W] ? (~d + 1'b1) : d;
  endfunction

endpackage

[rtl/aad_ring.sv]
// ----------------------------------------------------------------------------
// Movement history ring
// Single-port-write, single-port-read memory with a registered read word.
// ----------------------------------------------------------------------------
module aad_ring
  import aad_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [MOV_W-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [MOV_W-1:0]         rd_data
);

  logic [MOV_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/adaptive_axis_deadband_core.sv]
// ----------------------------------------------------------------------------
// Adaptive axis deadband core
// Holds an axis at a stable value once its recent movement settles, and lets
// it go again on a large jump.
// ----------------------------------------------------------------------------
// Latency: a word accepted at one edge shows its result on the next cycle.
// Throughput: one word per cycle while the result side is ready; the running
// movement sum is updated in the accept cycle, with the ring entry it retires
// already waiting in the registered read word of the history memory.
// Reset (synchronous, rst_n low) clears all control state, sets deadband_size
// to 0 and settle_duration to 500; the history memory itself is not cleared.
// ----------------------------------------------------------------------------
module adaptive_axis_deadband_core
  import aad_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [TIME_W-1:0]          in_time_ms,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_value,
  output logic                       out_holding,
  // Configuration port
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int POS_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = MOV_W + $clog2(DEPTH);
  localparam int CMP_W  = SUM_W + 1;
  localparam int PROD_W = SETTLE_W + 1 + $clog2(DEPTH) + 1;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(DEPTH - 1);

  // Configuration registers.
  logic [SIZE_W-1:0]   deadband_size_r;
  logic [SETTLE_W-1:0] settle_duration_r;

  // Tracking state.
  logic                       started_r, started_nxt;
  logic signed [SAMPLE_W-1:0] prev_sampled_r, prev_sampled_nxt;
  logic signed [SAMPLE_W-1:0] held_value_r, held_value_nxt;
  logic [TIME_W-1:0]          prev_time_r, prev_time_nxt;
  logic                       hold_active_r, hold_active_nxt;
  logic                       captured_r, captured_nxt;
  logic [POS_W-1:0]           ring_pos_r, ring_pos_nxt;
  logic [CNT_W-1:0]           ring_count_r, ring_count_nxt;
  logic [SUM_W-1:0]           movement_sum_r, movement_sum_nxt;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_value_r, out_value_nxt;
  logic                       out_holding_r, out_holding_nxt;

  // History memory.
  logic             ring_we;
  logic [MOV_W-1:0] mv;
  logic [MOV_W-1:0] ring_rd_data;

  logic accept;
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign out_valid   = out_valid_r;
  assign out_value   = out_value_r;
  assign out_holding = out_holding_r;

  // The read address follows the next ring position, so the entry that the
  // next recorded movement replaces is always waiting in ring_rd_data. The
  // only write that can hit the address being read is the one made together
  // with a history clear, and then the count is zero and the word is unused.
  aad_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk    (clk),
    .we     (ring_we),
    .wr_addr(ring_pos_r),
    .wr_data(mv),
    .rd_addr(ring_pos_nxt),
    .rd_data(ring_rd_data)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_size_r   <= '0;
      settle_duration_r <= SETTLE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DEADBAND_SIZE:   deadband_size_r   <= cfg_data[SIZE_W-1:0];
        CFG_SETTLE_DURATION: settle_duration_r <= cfg_data[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath terms computed in parallel from the current state.
  logic [TIME_W-1:0]     elapsed;
  logic [SETTLE_W:0]     elapsed_p1;
  logic [PROD_W-1:0]     elapsed_scaled;
  logic                  tick;
  logic [SAMPLE_W:0]     diff_prev;
  logic [SAMPLE_W:0]     diff_held;
  logic                  ring_full;
  logic [SUM_W-1:0]      sum_base;
  logic [SUM_W-1:0]      sum_tick;
  logic [CNT_W-1:0]      count_tick;
  logic [POS_W-1:0]      pos_tick;
  logic [SIZE_W-3:0]     bound_p1;
  logic [CMP_W-1:0]      sum_limit;
  logic                  settled;

  always_comb begin
    // An interval of floor(settle / DEPTH) ms has elapsed exactly when
    // (elapsed + 1) * DEPTH exceeds settle; any elapsed time of 2^16 ms or
    // more is always past it.
    elapsed        = in_time_ms - prev_time_r;
    elapsed_p1     = {1'b0, elapsed[SETTLE_W-1:0]} + 1'b1;
    elapsed_scaled = PROD_W'(elapsed_p1) * PROD_W'(DEPTH);
    tick           = (|elapsed[TIME_W-1:SETTLE_W])
                     || (elapsed_scaled > PROD_W'(settle_duration_r));

    diff_prev = abs_diff(in_sample, prev_sampled_r);
    diff_held = abs_diff(in_sample, held_value_r);
    mv        = diff_prev[MOV_W-1:0];

    // Running sum: retire the oldest entry once the ring is full.
    ring_full  = (ring_count_r == CNT_FULL);
    sum_base   = ring_full ? (movement_sum_r - SUM_W'(ring_rd_data)) : movement_sum_r;
    sum_tick   = sum_base + SUM_W'(mv);
    count_tick = ring_full ? ring_count_r : (ring_count_r + 1'b1);
    pos_tick   = (ring_pos_r == POS_LAST) ? '0 : (ring_pos_r + 1'b1);

    // floor(sum / DEPTH) <= floor(size / 8) is the same as
    // sum < (floor(size / 8) + 1) * DEPTH.
    bound_p1  = {1'b0, deadband_size_r[SIZE_W-1:3]} + 1'b1;
    sum_limit = CMP_W'(bound_p1) * CMP_W'(DEPTH);
    settled   = {1'b0, sum_tick} < sum_limit;
  end

  // Per-word state update and result.
  logic capture_now;
  logic jump;

  always_comb begin
    started_nxt      = started_r;
    prev_sampled_nxt = prev_sampled_r;
    held_value_nxt   = held_value_r;
    prev_time_nxt    = prev_time_r;
    hold_active_nxt  = hold_active_r;
    captured_nxt     = captured_r;
    ring_pos_nxt     = ring_pos_r;
    ring_count_nxt   = ring_count_r;
    movement_sum_nxt = movement_sum_r;
    ring_we          = 1'b0;
    capture_now      = 1'b0;
    jump             = 1'b0;

    out_valid_nxt   = in_ready ? in_valid : out_valid_r;
    out_value_nxt   = out_value_r;
    out_holding_nxt = out_holding_r;

    if (accept) begin
      out_value_nxt   = in_sample;
      out_holding_nxt = 1'b0;

      if (deadband_size_r == '0) begin
        // Disabled: pass through, state untouched.
      end else if (!started_r) begin
        started_nxt      = 1'b1;
        prev_sampled_nxt = in_sample;
        held_value_nxt   = in_sample;
        prev_time_nxt    = in_time_ms;
        hold_active_nxt  = 1'b0;
        captured_nxt     = 1'b0;
      end else begin
        if (tick) begin
          ring_we          = 1'b1;
          movement_sum_nxt = sum_tick;
          ring_count_nxt   = count_tick;
          ring_pos_nxt     = pos_tick;
          prev_time_nxt    = in_time_ms;
          prev_sampled_nxt = in_sample;
          if (count_tick == CNT_FULL) begin
            if (settled) begin
              if (!captured_r) begin
                held_value_nxt = in_sample;
                captured_nxt   = 1'b1;
                capture_now    = 1'b1;
              end
              hold_active_nxt = 1'b1;
            end else begin
              hold_active_nxt = 1'b0;
              captured_nxt    = 1'b0;
            end
          end
        end

        // A fresh capture equals the sample, so it can never be a jump.
        jump = hold_active_nxt && !capture_now
               && (diff_held > (SAMPLE_W + 1)'(deadband_size_r));

        if (jump) begin
          hold_active_nxt  = 1'b0;
          captured_nxt     = 1'b0;
          held_value_nxt   = in_sample;
          ring_count_nxt   = '0;
          ring_pos_nxt     = '0;
          movement_sum_nxt = '0;
        end else if (hold_active_nxt) begin
          out_value_nxt   = held_value_nxt;
          out_holding_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r      <= 1'b0;
      prev_sampled_r <= '0;
      held_value_r   <= '0;
      prev_time_r    <= '0;
      hold_active_r  <= 1'b0;
      captured_r     <= 1'b0;
      ring_pos_r     <= '0;
      ring_count_r   <= '0;
      movement_sum_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      started_r      <= started_nxt;
      prev_sampled_r <= prev_sampled_nxt;
      held_value_r   <= held_value_nxt;
      prev_time_r    <= prev_time_nxt;
      hold_active_r  <= hold_active_nxt;
      captured_r     <= captured_nxt;
      ring_pos_r     <= ring_pos_nxt;
      ring_count_r   <= ring_count_nxt;
      movement_sum_r <= movement_sum_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r   <= out_value_nxt;
    out_holding_r <= out_holding_nxt;
  end

  // The fill count never passes the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ring_count_r <= CNT_FULL)
    else $error("ring count exceeds history depth");

  // An empty history always has a zero running sum.
  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (ring_count_r == '0) |-> (movement_sum_r == '0))
    else $error("running sum nonzero with empty history");

  // An armed hold always has a captured value, and needs a started tracker.
  a_hold_captured: assert property (@(posedge clk) disable iff (!rst_n)
    hold_active_r |-> (captured_r && started_r))
    else $error("hold armed without a captured value");

  // A holding word on the output reflects the armed hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_holding_r) |-> hold_active_r)
    else $error("holding word while hold is not armed");

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Adaptive axis deadband core testbench
// Streams timestamped axis words through the core under several deadband and
// settle settings and compares every result word against a cycle-free
// prediction of the hold logic kept in a small scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  import aad_pkg::*;

  localparam int HISTORY_DEPTH = 8;
  // Cycles without any handshake or register write before the run is given up.
  localparam int STALL_LIMIT   = 4000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       holding;
  } axis_result_t;

  // The scoreboard keeps its own copy of the hold state and the two registers.
  // Every accepted word is run through the prediction at once, and the result
  // it should produce is queued until the core hands out the matching word.
  class axis_hold_scoreboard;
    logic [SIZE_W-1:0]          window;
    logic [SETTLE_W-1:0]        settle;
    bit                         started;
    bit                         armed;
    bit                         captured;
    logic signed [SAMPLE_W-1:0] last_recorded;
    logic signed [SAMPLE_W-1:0] stable_value;
    logic [TIME_W-1:0]          last_record_time;
    logic [MOV_W-1:0]           movement_hist [HISTORY_DEPTH];
    int unsigned                hist_pos;
    int unsigned                hist_fill;
    logic [MOV_W+2:0]           movement_total;
    axis_result_t               expected_q [$];
    int unsigned                errors;

    function new();
      window = '0;
      settle = SETTLE_RESET;
      started = 1'b0;
      armed = 1'b0;
      captured = 1'b0;
      last_recorded = '0;
      stable_value = '0;
      last_record_time = '0;
      foreach (movement_hist[i]) movement_hist[i] = '0;
      hist_pos = 0;
      hist_fill = 0;
      movement_total = '0;
      errors = 0;
    endfunction

    function void set_config(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DEADBAND_SIZE:   window = data[SIZE_W-1:0];
        CFG_SETTLE_DURATION: settle = data[SETTLE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [MOV_W-1:0] distance(logic signed [SAMPLE_W-1:0] a,
                                        logic signed [SAMPLE_W-1:0] b);
      int d;
      d = int'(a) - int'(b);
      if (d < 0) d = -d;
      return MOV_W'(d);
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic [TIME_W-1:0] t);
      axis_result_t     r;
      logic [TIME_W-1:0] elapsed;
      logic [MOV_W-1:0] mv;
      r.value = s;
      r.holding = 1'b0;
      if (window == 0) begin
        // Bypass: nothing in the state moves.
      end else if (!started) begin
        last_recorded = s;
        stable_value = s;
        last_record_time = t;
        armed = 1'b0;
        captured = 1'b0;
        started = 1'b1;
      end else begin
        elapsed = t - last_record_time;
        if (elapsed >= settle / HISTORY_DEPTH) begin
          mv = distance(s, last_recorded);
          if (hist_fill >= HISTORY_DEPTH) movement_total -= movement_hist[hist_pos];
          movement_total += mv;
          movement_hist[hist_pos] = mv;
          hist_pos = (hist_pos + 1) % HISTORY_DEPTH;
          if (hist_fill < HISTORY_DEPTH) hist_fill++;
          last_record_time = t;
          last_recorded = s;
          if (hist_fill >= HISTORY_DEPTH) begin
            if (movement_total / HISTORY_DEPTH <= window / 8) begin
              if (!captured) begin
                stable_value = s;
                captured = 1'b1;
              end
              armed = 1'b1;
            end else begin
              armed = 1'b0;
              captured = 1'b0;
            end
          end
        end
        if (armed) begin
          if (distance(s, stable_value) > window) begin
            // A big jump lets go of the hold and starts the history over.
            armed = 1'b0;
            captured = 1'b0;
            stable_value = s;
            hist_fill = 0;
            hist_pos = 0;
            movement_total = '0;
          end else begin
            r.value = stable_value;
            r.holding = 1'b1;
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] value, logic holding);
      axis_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result word with none expected: expected none, actual value %0d holding %0b",
                 $time, value, holding);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (value !== e.value) begin
        $display("%0t: out_value mismatch: expected %0d, actual %0d", $time, e.value, value);
        errors++;
      end
      if (holding !== e.holding) begin
        $display("%0t: out_holding mismatch: expected %0b, actual %0b",
                 $time, e.holding, holding);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic [TIME_W-1:0]          in_time_ms = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_value;
  logic                       out_holding;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = CFG_DEADBAND_SIZE;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // While calm is set neither side inserts idle cycles.
  bit                         calm = 1'b1;
  logic [TIME_W-1:0]          now_ms = '0;
  int unsigned                quiet_cycles = 0;
  axis_hold_scoreboard        sb = new();

  always #6 clk = ~clk;

  adaptive_axis_deadband_core #(
    .DEPTH(HISTORY_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .in_time_ms (in_time_ms),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_holding(out_holding),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // While calm is clear, the result side stalls with a chance of roughly 18 in a hundred.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 18);
  end

  // Handshakes are observed at the edge where they complete. Every accepted
  // word feeds the prediction, every accepted result word is checked, and a
  // watchdog stops the run if the core goes quiet for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_sample(in_sample, in_time_ms);
      if (out_valid && out_ready) sb.check_result(out_value, out_holding);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] to_sample(input int v);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return SAMPLE_W'(v);
  endfunction

  // Offers one word and returns at the edge where it is taken. Idle cycles
  // are inserted before the word only, so valid never drops while it waits.
  task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_time_ms <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  // Registers only change with the input channel quiet and every result
  // delivered. Both registers are written on back-to-back edges.
  task automatic reconfigure(input logic [SIZE_W-1:0] size, input logic [SETTLE_W-1:0] span);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DEADBAND_SIZE;
    cfg_data <= CFG_DATA_W'(size);
    @(posedge clk);
    cfg_index <= CFG_SETTLE_DURATION;
    cfg_data <= span;
    sb.set_config(CFG_DEADBAND_SIZE, CFG_DATA_W'(size));
    sb.set_config(CFG_SETTLE_DURATION, span);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Most of the traffic is settling runs: a random level with a small wobble
  // and timestamps paced at the recording interval, so the history fills and
  // the hold arms. A run may end in a jump out of the window. The rest is
  // arbitrary noise and runs paced too fast or wobbling too much to settle.
  task automatic random_phase(input logic [SIZE_W-1:0] size, input logic [SETTLE_W-1:0] span,
                              input int unsigned count, input bit quiet);
    int unsigned       sent;
    int unsigned       run_len;
    int                base;
    int                wobble;
    int                lim;
    int                v;
    int                mode;
    logic [TIME_W-1:0] gap;
    reconfigure(size, span);
    calm <= quiet;
    gap = span / HISTORY_DEPTH;
    lim = size;
    // Start some phases just short of the timestamp wrap.
    if ($urandom_range(2) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(4000);
    sent = 0;
    while (sent < count) begin
      mode = $urandom_range(9);
      base = int'($urandom_range(65535)) - 32768;
      if (mode == 7) begin
        run_len = $urandom_range(1, 4);
        repeat (run_len) begin
          if ($urandom_range(1) == 1) now_ms = $urandom();
          else now_ms += $urandom_range(0, gap * 2 + 2);
          send_word(SAMPLE_W'($urandom()), now_ms);
        end
      end else if (mode == 8) begin
        // Paced below the interval and wobbling wide.
        run_len = $urandom_range(4, 12);
        repeat (run_len) begin
          now_ms += (gap == 0) ? 0 : $urandom_range(0, gap - 1);
          v = base + int'($urandom_range(0, 2 * lim + 2)) - lim - 1;
          send_word(to_sample(v), now_ms);
        end
      end else begin
        run_len = $urandom_range(9, 22);
        if ($urandom_range(3) == 0) wobble = lim / 4 + 1;
        else wobble = $urandom_range(0, lim / 16);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(7) == 0) now_ms += $urandom_range(0, gap);
          else now_ms += gap + $urandom_range(0, 3);
          v = base + int'($urandom_range(0, 2 * wobble)) - wobble;
          if (i == run_len - 1 && $urandom_range(1) == 1) begin
            v = lim + wobble + 1 + int'($urandom_range(0, 50));
            v = ($urandom_range(1) == 1) ? base + v : base - v;
          end
          send_word(to_sample(v), now_ms);
        end
      end
      sent += run_len;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset the deadband is zero: words pass straight through.
    send_word(16'sh8000, 32'h0000_0000);
    send_word(16'sh7FFF, 32'hFFFF_FFFF);
    send_word(-16'sd1, 32'h5555_AAAA);

    // Window of 100 with a 100 ms recording interval. The first word only
    // seeds the state; eight quiet recordings then fill the history and arm
    // the hold, and a nearby word inside the interval is held.
    reconfigure(15'd100, 16'd800);
    now_ms = 32'd1000;
    send_word(to_sample(1000), now_ms);
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      now_ms += 100;
      send_word(to_sample(1000 + i % 3), now_ms);
    end
    now_ms += 1;
    send_word(to_sample(1060), now_ms);

    // Switching the block off with the hold armed still reports no hold.
    reconfigure(15'd0, 16'd800);
    send_word(to_sample(1060), now_ms);

    // Back on, a jump past the window drops the hold and clears the history;
    // then the largest possible movement between two recordings.
    reconfigure(15'd100, 16'd800);
    now_ms += 1;
    send_word(to_sample(1300), now_ms);
    now_ms += 200;
    send_word(16'sh8000, now_ms);
    now_ms += 200;
    send_word(16'sh7FFF, now_ms);

    // Random phases across window and interval settings, the extremes among
    // them. Settle durations below the history depth record every word. One
    // phase runs with no idling on either side.
    random_phase(15'd16, 16'd0, 70, 1'b0);
    random_phase(15'd200, SETTLE_RESET, 80, 1'b0);
    random_phase(15'd32767, 16'd65535, 90, 1'b1);
    random_phase(15'd1, 16'd7, 70, 1'b0);
    random_phase(15'd0, 16'd300, 30, 1'b0);
    random_phase(15'd8, 16'd64, 70, 1'b0);
    random_phase(15'd3000, 16'd1000, 60, 1'b0);
    random_phase(15'd120, 16'd8, 80, 1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
